FILE: sv/mat_pkg.sv
// ----------------------------------------------------------------------------
// mat_pkg: shared types and constants of the address translator
// Operation and target codes, mapping state and result structs.
// ----------------------------------------------------------------------------
package mat_pkg;

  // Base of the unmapped I/O page, compared against the upper address nibble
  localparam logic [15:0] IO_PAGE_BASE = 16'hD000;
  localparam logic [15:0] PAGE_MASK    = 16'hF000;
  localparam logic [16:0] ROM_BASE_RST = 17'h0E000;
  localparam logic [7:0]  MB_SELECT    = 8'h0F;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_MAP   = 2'd2,
    OP_EOM   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    TGT_RAM  = 2'd0,
    TGT_IO   = 2'd1,
    TGT_ROM  = 2'd2,
    TGT_NONE = 2'd3
  } target_e;

  // Mapping state held between items
  typedef struct packed {
    logic [7:0]  low_mb;
    logic [7:0]  high_mb;
    logic [11:0] low_off;
    logic [11:0] high_off;
    logic [7:0]  enables;
    logic        inhibit;
  } map_state_t;

  // Command into the mapping registers
  typedef struct packed {
    logic       valid;
    op_e        op;
    logic [7:0] reg_a;
    logic [7:0] reg_x;
    logic [7:0] reg_y;
    logic [7:0] reg_z;
  } map_cmd_t;

  // One translated result
  typedef struct packed {
    logic [27:0] phys_address;
    target_e     target;
    logic [7:0]  bus_data;
    logic        interrupts_inhibited;
  } result_t;

endpackage

FILE: sv/mat_map_regs.sv
// ----------------------------------------------------------------------------
// mat_map_regs: mapping state registers
// Loads megabytes, offsets and block enables and sets inhibit on MAP, clears inhibit on EOM.
// ----------------------------------------------------------------------------
module mat_map_regs
  import mat_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  map_cmd_t   cmd_i,
  output map_state_t state_o
);

  map_state_t state_q, state_d;

  // Work out the state left by the item that advances
  always_comb begin
    state_d = state_q;
    if (cmd_i.valid) begin
      unique case (cmd_i.op)
        OP_MAP: begin
          state_d.inhibit = 1'b1;
          if (cmd_i.reg_x == MB_SELECT) begin
            state_d.low_mb = cmd_i.reg_a;
          end else begin
            state_d.low_off      = {cmd_i.reg_x[3:0], cmd_i.reg_a};
            state_d.enables[3:0] = cmd_i.reg_x[7:4];
          end
          if (cmd_i.reg_z == MB_SELECT) begin
            state_d.high_mb = cmd_i.reg_y;
          end else begin
            state_d.high_off     = {cmd_i.reg_z[3:0], cmd_i.reg_y};
            state_d.enables[7:4] = cmd_i.reg_z[7:4];
          end
        end
        OP_EOM: begin
          state_d.inhibit = 1'b0;
        end
        OP_READ, OP_WRITE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

FILE: sv/mat_xlate.sv
// ----------------------------------------------------------------------------
// mat_xlate: address translation logic
// Maps a CPU access to a physical address and picks RAM, I/O or ROM.
// ----------------------------------------------------------------------------
module mat_xlate
  import mat_pkg::*;
(
  input  map_state_t  state_i,
  input  logic [16:0] rom_base_i,
  input  op_e         operation_i,
  input  logic [15:0] cpu_address_i,
  input  logic [7:0]  write_data_i,
  output result_t     result_o
);

  logic        upper;
  logic        mapped;
  logic        is_write;
  logic [19:0] offset;
  logic [19:0] sum;
  logic [7:0]  mb;
  logic [7:0]  fwd_data;

  assign upper    = cpu_address_i[15];
  assign mapped   = state_i.enables[cpu_address_i[15:13]];
  assign is_write = (operation_i == OP_WRITE);
  assign offset   = {(upper ? state_i.high_off : state_i.low_off), 8'h00};
  assign sum      = offset + {4'h0, cpu_address_i};
  assign mb       = upper ? state_i.high_mb : state_i.low_mb;
  assign fwd_data = is_write ? write_data_i : 8'h00;

  // Select the result for this operation
  always_comb begin
    result_o = '0;
    result_o.interrupts_inhibited = state_i.inhibit;
    unique case (operation_i)
      OP_MAP: begin
        result_o.target = TGT_NONE;
        result_o.interrupts_inhibited = 1'b1;
      end
      OP_EOM: begin
        result_o.target = TGT_NONE;
        result_o.interrupts_inhibited = 1'b0;
      end
      OP_READ, OP_WRITE: begin
        if (mapped) begin
          result_o.phys_address = {mb, sum};
          result_o.target       = TGT_RAM;
          result_o.bus_data     = fwd_data;
        end else begin
          result_o.phys_address = {12'h000, cpu_address_i};
          priority if ((cpu_address_i & PAGE_MASK) == IO_PAGE_BASE) begin
            result_o.target   = TGT_IO;
            result_o.bus_data = fwd_data;
          end else if (is_write && ({1'b0, cpu_address_i} >= rom_base_i)) begin
            result_o.target = TGT_ROM;
          end else begin
            result_o.target   = TGT_RAM;
            result_o.bus_data = fwd_data;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/map_address_translator.sv
// ----------------------------------------------------------------------------
// map_address_translator: memory map unit with 28-bit physical addresses
// One item per cycle while the output is not stalled.
// The input register feeds the translation logic, which feeds the result
// register; MAP and EOM update the mapping state as they leave the input.
// Reset clears mapping and inhibit flag, and sets the ROM base to 0xE000.
// ----------------------------------------------------------------------------
module map_address_translator
  import mat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_rom_base_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] cpu_address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  reg_a_i,
  input  logic [7:0]  reg_x_i,
  input  logic [7:0]  reg_y_i,
  input  logic [7:0]  reg_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [27:0] phys_address_o,
  output logic [1:0]  target_o,
  output logic [7:0]  bus_data_o,
  output logic        interrupts_inhibited_o
);

  logic [16:0] rom_base_q;
  logic        in_vld_q;
  op_e         op_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;
  logic [7:0]  a_q, x_q, y_q, z_q;
  logic        out_vld_q;
  result_t     res_q, res_d;
  logic        out_free;
  logic        advance;
  logic        in_take;
  map_cmd_t    cmd;
  map_state_t  state;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_base_q <= ROM_BASE_RST;
    end else if (cfg_valid_i) begin
      rom_base_q <= cfg_rom_base_i;
    end
  end

  // Pipeline handshake
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= op_e'(operation_i);
      addr_q <= cpu_address_i;
      data_q <= write_data_i;
      a_q    <= reg_a_i;
      x_q    <= reg_x_i;
      y_q    <= reg_y_i;
      z_q    <= reg_z_i;
    end
  end

  // Update mapping as the item advances
  assign cmd = '{valid: advance, op: op_q, reg_a: a_q, reg_x: x_q,
                 reg_y: y_q, reg_z: z_q};

  mat_map_regs u_map_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .state_o (state)
  );

  mat_xlate u_xlate (
    .state_i       (state),
    .rom_base_i    (rom_base_q),
    .operation_i   (op_q),
    .cpu_address_i (addr_q),
    .write_data_i  (data_q),
    .result_o      (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o            = out_vld_q;
  assign phys_address_o         = res_q.phys_address;
  assign target_o               = res_q.target;
  assign bus_data_o             = res_q.bus_data;
  assign interrupts_inhibited_o = res_q.interrupts_inhibited;

endmodule
